/* design/rau_pkg.sv */
// rational arithmetic unit: shared package
// widths, payload and result structs, unit handshake structs, sequencer states
// no dependencies
`default_nettype none

package rau_pkg;

  localparam int IntW   = 32;
  localparam int FieldW = 32;

  typedef logic signed [IntW-1:0]   data_t;
  typedef logic        [IntW-1:0]   umag_t;
  typedef logic signed [2*IntW-1:0] wide_t;
  typedef logic        [2*IntW-1:0] uwide_t;
  typedef logic signed [FieldW-1:0] field_t;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MULTIPLY,
    OP_SCALE,
    OP_COMPARE
  } op_e;

  typedef struct packed {
    op_e    operation;
    field_t a_num;
    field_t a_den;
    field_t b_num;
    field_t b_den;
  } req_t;

  typedef struct packed {
    field_t result_num;
    field_t result_den;
    logic   is_less;
    logic   is_greater;
    logic   fault;
  } res_t;

  typedef struct packed {
    logic   start;
    logic   long_mode;
    uwide_t dividend;
    umag_t  divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    umag_t quo;
    umag_t rem;
  } div_rsp_t;

  typedef struct packed {
    logic  start;
    data_t a;
    data_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    wide_t prod;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_GCD_TEST,
    ST_GCD_WAIT,
    ST_DM_WAIT,
    ST_MUL_WAIT,
    ST_SC_TEST,
    ST_SC_DIV,
    ST_SC_MQD,
    ST_SC_MQN,
    ST_SC_MP,
    ST_SC_DP,
    ST_CMP_WAIT,
    ST_DONE
  } state_e;

  function automatic umag_t mag(data_t x);
    return x[IntW-1] ? umag_t'(-x) : umag_t'(x);
  endfunction

endpackage

`default_nettype wire

/* design/rau_if.sv */
// rational arithmetic unit: request and result channel interfaces
// valid/ready handshake with payload; depends on rau_pkg
`default_nettype none

interface rau_req_if;
  import rau_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  field_t     a_num;
  field_t     a_den;
  field_t     b_num;
  field_t     b_den;
  modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
  import rau_pkg::*;
  logic   valid;
  logic   ready;
  field_t result_num;
  field_t result_den;
  logic   is_less;
  logic   is_greater;
  logic   fault;
  modport source (output valid, result_num, result_den, is_less, is_greater, fault,
                  input ready);
  modport sink (input valid, result_num, result_den, is_less, is_greater, fault,
                output ready);
endinterface

`default_nettype wire

/* design/rau_div.sv */
// rational arithmetic unit: shared restoring divider, one quotient bit per cycle
// short mode divides IntW bits, long mode 2*IntW bits; depends on rau_pkg
`default_nettype none

module rau_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rau_pkg::div_req_t   req_i,
  output rau_pkg::div_rsp_t   rsp_o
);
  import rau_pkg::*;

  localparam int CntW = $clog2(2*IntW+1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  umag_t           rem_q, rem_d;
  uwide_t          quo_q, quo_d;
  umag_t           dsr_q, dsr_d;

  logic [IntW:0]   trial;
  logic [IntW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quo_q[2*IntW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      if (req_i.long_mode) begin
        quo_d = req_i.dividend;
        cnt_d = CntW'(2*IntW);
      end else begin
        quo_d = {req_i.dividend[IntW-1:0], umag_t'(0)};
        cnt_d = CntW'(IntW);
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[IntW-1:0] : trial[IntW-1:0];
      quo_d = {quo_q[2*IntW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q[IntW-1:0];
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

/* design/rau_mul.sv */
// rational arithmetic unit: shared signed multiplier with registered product
// full 2*IntW product in the cycle after start; depends on rau_pkg
`default_nettype none

module rau_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rau_pkg::mul_req_t   req_i,
  output rau_pkg::mul_rsp_t   rsp_o
);
  import rau_pkg::*;

  data_t a_s;
  data_t b_s;
  wide_t prod_d;
  wide_t prod_q;
  logic  done_q;

  assign a_s    = req_i.a;
  assign b_s    = req_i.b;
  assign prod_d = a_s * b_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= prod_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

`default_nettype wire

/* design/rau_seq.sv */
// rational arithmetic unit: sequencer and operand registers
// drives the shared divider and multiplier; depends on rau_pkg, rau_div, rau_mul
`default_nettype none

module rau_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  rau_pkg::req_t   req_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output rau_pkg::res_t   res_o
);
  import rau_pkg::*;

  localparam int StepW = 5;

  typedef enum logic [2:0] {U_GCD, U_DIVM, U_MUL, U_CHKZ, U_CHK1, U_END} uop_e;
  typedef enum logic [2:0] {S_AN, S_AD, S_BN, S_BD, S_G0, S_G1} sel_e;

  typedef struct packed {
    uop_e kind;
    sel_e src_a;
    sel_e src_b;
    sel_e dst;
  } uop_t;

  function automatic uop_t mk(uop_e k, sel_e a, sel_e b, sel_e d);
    uop_t u;
    u.kind  = k;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    return u;
  endfunction

  function automatic uop_t uop_at(op_e op, logic [StepW-1:0] step);
    uop_t u;
    u = mk(U_END, S_AN, S_AD, S_AN);
    if (op == OP_REDUCE) begin
      case (step)
        5'd0:    u = mk(U_GCD, S_AN, S_AD, S_G0);
        5'd1:    u = mk(U_CHK1, S_G0, S_G0, S_G0);
        5'd2:    u = mk(U_DIVM, S_AN, S_G0, S_AN);
        5'd3:    u = mk(U_DIVM, S_AD, S_G0, S_AD);
        default: u = mk(U_END, S_AN, S_AD, S_AN);
      endcase
    end else begin
      case (step)
        5'd0:    u = mk(U_GCD, S_AN, S_BD, S_G0);
        5'd1:    u = mk(U_GCD, S_BN, S_AD, S_G1);
        5'd2:    u = mk(U_CHKZ, S_G0, S_G1, S_G0);
        5'd3:    u = mk(U_DIVM, S_AN, S_G0, S_AN);
        5'd4:    u = mk(U_DIVM, S_BN, S_G1, S_BN);
        5'd5:    u = mk(U_DIVM, S_AD, S_G1, S_AD);
        5'd6:    u = mk(U_DIVM, S_BD, S_G0, S_BD);
        5'd7:    u = mk(U_GCD, S_AN, S_AD, S_G0);
        5'd8:    u = mk(U_GCD, S_BN, S_BD, S_G1);
        5'd9:    u = mk(U_CHKZ, S_G0, S_G1, S_G0);
        5'd10:   u = mk(U_DIVM, S_AN, S_G0, S_AN);
        5'd11:   u = mk(U_DIVM, S_AD, S_G0, S_AD);
        5'd12:   u = mk(U_DIVM, S_BN, S_G1, S_BN);
        5'd13:   u = mk(U_DIVM, S_BD, S_G1, S_BD);
        5'd14:   u = mk(U_MUL, S_AN, S_BN, S_AN);
        5'd15:   u = mk(U_MUL, S_AD, S_BD, S_AD);
        default: u = mk(U_END, S_AN, S_AD, S_AN);
      endcase
    end
    return u;
  endfunction

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  op_e              op_q, op_d;
  data_t            an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  data_t            g0_q, g0_d, g1_q, g1_d;
  umag_t            x_q, x_d, y_q, y_d;
  data_t            acc_q, acc_d, q_q, q_d;
  logic             neg_q, neg_d;
  logic             br_q, br_d;
  res_t             res_q, res_d;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  uop_t  u;
  data_t rd_a, rd_b;
  logic  wr_en;
  data_t wv;
  data_t sum_w;
  data_t lo;
  data_t qv;
  wide_t an_w;
  logic  ad_pos;

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rau_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign u = uop_at(op_q, step_q);

  always_comb begin
    case (u.src_a)
      S_AN:    rd_a = an_q;
      S_AD:    rd_a = ad_q;
      S_BN:    rd_a = bn_q;
      S_BD:    rd_a = bd_q;
      S_G0:    rd_a = g0_q;
      S_G1:    rd_a = g1_q;
      default: rd_a = an_q;
    endcase
  end

  always_comb begin
    case (u.src_b)
      S_AN:    rd_b = an_q;
      S_AD:    rd_b = ad_q;
      S_BN:    rd_b = bn_q;
      S_BD:    rd_b = bd_q;
      S_G0:    rd_b = g0_q;
      S_G1:    rd_b = g1_q;
      default: rd_b = ad_q;
    endcase
  end

  assign sum_w  = an_q + ad_q;
  assign lo     = data_t'(mul_rsp.prod[IntW-1:0]);
  assign qv     = neg_q ? data_t'(-div_rsp.quo) : data_t'(div_rsp.quo);
  assign an_w   = wide_t'(an_q);
  assign ad_pos = !ad_q[IntW-1] && (ad_q != '0);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    op_d    = op_q;
    an_d    = an_q;
    ad_d    = ad_q;
    bn_d    = bn_q;
    bd_d    = bd_q;
    g0_d    = g0_q;
    g1_d    = g1_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    q_d     = q_q;
    neg_d   = neg_q;
    br_d    = br_q;
    res_d   = res_q;
    div_req = '0;
    mul_req = '0;
    wr_en   = 1'b0;
    wv      = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d    = req_i.operation;
          an_d    = data_t'(req_i.a_num);
          ad_d    = data_t'(req_i.a_den);
          bn_d    = data_t'(req_i.b_num);
          bd_d    = data_t'(req_i.b_den);
          step_d  = '0;
          acc_d   = '0;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (op_q)
          OP_SCALE: begin
            state_d = ST_SC_TEST;
          end
          OP_COMPARE: begin
            mul_req.start = 1'b1;
            mul_req.a     = bn_q;
            mul_req.b     = ad_q;
            state_d       = ST_CMP_WAIT;
          end
          default: begin
            case (u.kind)
              U_GCD: begin
                x_d     = mag(rd_a);
                y_d     = mag(rd_b);
                state_d = ST_GCD_TEST;
              end
              U_DIVM: begin
                div_req.start    = 1'b1;
                div_req.dividend = uwide_t'(mag(rd_a));
                div_req.divisor  = mag(rd_b);
                neg_d            = rd_a[IntW-1];
                state_d          = ST_DM_WAIT;
              end
              U_MUL: begin
                mul_req.start = 1'b1;
                mul_req.a     = rd_a;
                mul_req.b     = rd_b;
                state_d       = ST_MUL_WAIT;
              end
              U_CHKZ: begin
                if (g0_q == '0 || g1_q == '0) begin
                  res_d       = '0;
                  res_d.fault = 1'b1;
                  state_d     = ST_DONE;
                end else begin
                  step_d = step_q + 1'b1;
                end
              end
              U_CHK1: begin
                if (umag_t'(g0_q) > umag_t'(1)) begin
                  step_d = step_q + 1'b1;
                end else begin
                  res_d            = '0;
                  res_d.result_num = field_t'(an_q);
                  res_d.result_den = field_t'(ad_q);
                  state_d          = ST_DONE;
                end
              end
              default: begin
                res_d            = '0;
                res_d.result_num = field_t'(an_q);
                res_d.result_den = field_t'(ad_q);
                state_d          = ST_DONE;
              end
            endcase
          end
        endcase
      end
      ST_GCD_TEST: begin
        if (y_q == '0) begin
          wr_en   = 1'b1;
          wv      = data_t'(x_q);
          step_d  = step_q + 1'b1;
          state_d = ST_DISPATCH;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = uwide_t'(x_q);
          div_req.divisor  = y_q;
          state_d          = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (div_rsp.done) begin
          x_d     = y_q;
          y_d     = div_rsp.rem;
          state_d = ST_GCD_TEST;
        end
      end
      ST_DM_WAIT: begin
        if (div_rsp.done) begin
          wr_en   = 1'b1;
          wv      = qv;
          step_d  = step_q + 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          wr_en   = 1'b1;
          wv      = lo;
          step_d  = step_q + 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_SC_TEST: begin
        res_d = '0;
        if (an_q == '0) begin
          res_d.result_num = field_t'(acc_q);
          state_d          = ST_DONE;
        end else if (an_q == ad_q) begin
          res_d.result_num = field_t'(data_t'(acc_q + bn_q));
          state_d          = ST_DONE;
        end else if (sum_w == '0) begin
          res_d.result_num = field_t'(data_t'(acc_q - bn_q));
          state_d          = ST_DONE;
        end else if (ad_q == '0) begin
          res_d.fault = 1'b1;
          state_d     = ST_DONE;
        end else if (mag(bn_q) > mag(ad_q)) begin
          div_req.start    = 1'b1;
          div_req.dividend = uwide_t'(mag(bn_q));
          div_req.divisor  = mag(ad_q);
          neg_d            = bn_q[IntW-1] ^ ad_q[IntW-1];
          br_d             = 1'b0;
          state_d          = ST_SC_DIV;
        end else if (mag(an_q) > mag(ad_q)) begin
          div_req.start    = 1'b1;
          div_req.dividend = uwide_t'(mag(an_q));
          div_req.divisor  = mag(ad_q);
          neg_d            = an_q[IntW-1] ^ ad_q[IntW-1];
          br_d             = 1'b1;
          state_d          = ST_SC_DIV;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = bn_q;
          mul_req.b     = an_q;
          state_d       = ST_SC_MP;
        end
      end
      ST_SC_DIV: begin
        if (div_rsp.done) begin
          q_d           = qv;
          mul_req.start = 1'b1;
          mul_req.a     = qv;
          mul_req.b     = ad_q;
          state_d       = ST_SC_MQD;
        end
      end
      ST_SC_MQD: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          if (!br_q) begin
            bn_d      = bn_q - lo;
            mul_req.a = q_q;
            mul_req.b = an_q;
          end else begin
            an_d      = an_q - lo;
            mul_req.a = bn_q;
            mul_req.b = q_q;
          end
          state_d = ST_SC_MQN;
        end
      end
      ST_SC_MQN: begin
        if (mul_rsp.done) begin
          acc_d   = acc_q + lo;
          state_d = ST_SC_TEST;
        end
      end
      ST_SC_MP: begin
        if (mul_rsp.done) begin
          div_req.start     = 1'b1;
          div_req.long_mode = 1'b1;
          div_req.dividend  = mul_rsp.prod[2*IntW-1] ? uwide_t'(-mul_rsp.prod)
                                                     : uwide_t'(mul_rsp.prod);
          div_req.divisor   = mag(ad_q);
          neg_d             = mul_rsp.prod[2*IntW-1] ^ ad_q[IntW-1];
          state_d           = ST_SC_DP;
        end
      end
      ST_SC_DP: begin
        if (div_rsp.done) begin
          res_d            = '0;
          res_d.result_num = field_t'(data_t'(acc_q + qv));
          state_d          = ST_DONE;
        end
      end
      ST_CMP_WAIT: begin
        if (mul_rsp.done) begin
          res_d = '0;
          if (ad_pos) begin
            res_d.is_less    = an_w < mul_rsp.prod;
            res_d.is_greater = an_w > mul_rsp.prod;
          end else begin
            res_d.is_less    = an_w > mul_rsp.prod;
            res_d.is_greater = an_w < mul_rsp.prod;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (wr_en) begin
      case (u.dst)
        S_AN:    an_d = wv;
        S_AD:    ad_d = wv;
        S_BN:    bn_d = wv;
        S_BD:    bd_d = wv;
        S_G0:    g0_d = wv;
        S_G1:    g1_d = wv;
        default: g0_d = wv;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      op_q    <= OP_REDUCE;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q  <= an_d;
    ad_q  <= ad_d;
    bn_q  <= bn_d;
    bd_q  <= bd_d;
    g0_q  <= g0_d;
    g1_q  <= g1_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    q_q   <= q_d;
    neg_q <= neg_d;
    br_q  <= br_d;
    res_q <= res_d;
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* design/rational_arith_unit.sv */
// rational arithmetic unit: top level with request and result channels
// one request in, one result out; depends on rau_pkg, rau_if, rau_seq
//
// usage: req_i carries one request (operation, a_num, a_den, b_num, b_den);
// it is taken when valid and ready are both high. rsp_o returns exactly one
// result per request, in order, held in an output register until taken.
// ready is high only while the sequencer is idle: one request at a time, so
// the next request is not taken before the sequencer has handed its result on.
// all work runs on one shared restoring divider (one quotient bit a cycle,
// short divides for gcd and quotient steps, a wide divide in scale) and one
// registered multiplier. reduce runs one gcd and, if it is above one, two
// divides; multiply runs four gcds, eight divides and two products; scale
// loops on divides and products until done; compare takes one product.
// a stalled receiver holds the result; the next request is still taken and
// its result waits in the sequencer until the output register frees up.
// reset clears the sequencer and the output valid; no clearing pass.
`default_nettype none

module rational_arith_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_req_if.sink   req_i,
  rau_rsp_if.source rsp_o
);
  import rau_pkg::*;

  req_t req;
  res_t res;
  logic res_valid;
  logic res_ready;
  logic out_valid_q;
  res_t out_q;

  assign req.operation = op_e'(req_i.operation);
  assign req.a_num     = req_i.a_num;
  assign req.a_den     = req_i.a_den;
  assign req.b_num     = req_i.b_num;
  assign req.b_den     = req_i.b_den;

  rau_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.result_num = out_q.result_num;
  assign rsp_o.result_den = out_q.result_den;
  assign rsp_o.is_less    = out_q.is_less;
  assign rsp_o.is_greater = out_q.is_greater;
  assign rsp_o.fault      = out_q.fault;

endmodule

`default_nettype wire
